/* sv/ascp_pkg.sv */
// ----------------------------------------------------------------------------
// ascp_pkg: shared types, constants and round function of the Ascon-p block
// Holds the 320-bit state type, the round constants, round-count codes and
// the single-round combinational function used by every cell of the chain.
// ----------------------------------------------------------------------------
package ascp_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned N_WORDS  = 5;
    localparam int unsigned N_ROUNDS = 12;
    localparam int unsigned ROUND_W  = $clog2(N_ROUNDS);
    localparam int unsigned OP_W     = 2;

    // round-count codes carried in op
    localparam logic [OP_W-1:0] OP_R12 = 2'd0;
    localparam logic [OP_W-1:0] OP_R8  = 2'd1;
    localparam logic [OP_W-1:0] OP_R6  = 2'd2;

    // first round index of each form
    localparam logic [ROUND_W-1:0] FIRST_R12 = 4'd0;
    localparam logic [ROUND_W-1:0] FIRST_R8  = 4'd4;
    localparam logic [ROUND_W-1:0] FIRST_R6  = 4'd6;

    typedef logic [WORD_W-1:0]             t_word;
    typedef logic [N_WORDS-1:0][WORD_W-1:0] t_state;

    // one item as it travels down the chain
    typedef struct packed {
        logic [OP_W-1:0] op;
        t_state          state;
    } t_item;

    localparam logic [N_ROUNDS-1:0][7:0] RC_TABLE = {
        8'h4B, 8'h5A, 8'h69, 8'h78, 8'h87, 8'h96,
        8'hA5, 8'hB4, 8'hC3, 8'hD2, 8'hE1, 8'hF0
    };

    // rotate right by a constant amount
    function automatic t_word rotr(input t_word v, input int unsigned n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

    // first round index for a selector; the unused code runs like six rounds
    function automatic logic [ROUND_W-1:0] first_round(input logic [OP_W-1:0] op);
        logic [ROUND_W-1:0] f;
        unique case (op)
            OP_R12:  f = FIRST_R12;
            OP_R8:   f = FIRST_R8;
            default: f = FIRST_R6;
        endcase
        return f;
    endfunction

    // one Ascon round: constant addition, S-box layer, linear layer
    function automatic t_state perm_round(input t_state s_in, input logic [7:0] rc);
        t_state s;
        t_word  n0, n1, n2, n3, n4;
        t_word  a0, a1, a2, a3, a4;
        t_state r;
        s    = s_in;
        s[2] = s[2] ^ {{(WORD_W-8){1'b0}}, rc};
        // pre-mixing
        s[0] = s[0] ^ s[4];
        s[4] = s[4] ^ s[3];
        s[2] = s[2] ^ s[1];
        // chi-like step
        n0 = ~s[0] & s[1];
        n1 = ~s[1] & s[2];
        n2 = ~s[2] & s[3];
        n3 = ~s[3] & s[4];
        n4 = ~s[4] & s[0];
        a0 = s[0] ^ n1;
        a1 = s[1] ^ n2;
        a2 = s[2] ^ n3;
        a3 = s[3] ^ n4;
        a4 = s[4] ^ n0;
        // post-mixing
        a1 = a1 ^ a0;
        a0 = a0 ^ a4;
        a3 = a3 ^ a2;
        a2 = ~a2;
        // linear diffusion
        r[0] = a0 ^ rotr(a0, 19) ^ rotr(a0, 28);
        r[1] = a1 ^ rotr(a1, 61) ^ rotr(a1, 39);
        r[2] = a2 ^ rotr(a2, 1)  ^ rotr(a2, 6);
        r[3] = a3 ^ rotr(a3, 10) ^ rotr(a3, 17);
        r[4] = a4 ^ rotr(a4, 7)  ^ rotr(a4, 41);
        return r;
    endfunction

endpackage

/* sv/ascp_cell.sv */
// ----------------------------------------------------------------------------
// ascp_cell: one round cell of the permutation chain
// Applies round IDX to the item it takes from its left neighbor (or passes it
// unchanged when the item's form starts later) and holds it for the right one.
// ----------------------------------------------------------------------------
module ascp_cell
    import ascp_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    localparam logic [ROUND_W-1:0] IDX_V = ROUND_W'(IDX);
    localparam logic [7:0]         RC    = RC_TABLE[IDX];

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // free slot, or the held item leaves this cycle
    assign o_ready = !r_valid || i_ready;

    // round only for forms that have reached this index
    always_comb begin
        n_item.op = i_item.op;
        if (IDX_V >= first_round(i_item.op)) begin
            n_item.state = perm_round(i_item.state, RC);
        end else begin
            n_item.state = i_item.state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* sv/ascon_permutation.sv */
// ----------------------------------------------------------------------------
// ascon_permutation: Ascon-p permutation on a 320-bit state
// Twelve round cells in a row; each item moves one cell per cycle unless held by a receiver stall.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries the five state words and the
//   round-count selector i_op (0: 12 rounds, 1: 8 rounds, 2 or 3: 6 rounds).
//   Output channel (o_valid / i_ready) carries the five permuted words.
//   Every item passes all twelve cells in turn, one cell per cycle while the
//   receiver does not stall; the result is registered in the last cell and
//   offered from there.
//   Shorter forms pass unchanged through the cells of the rounds they skip.
//   Throughput: one item per cycle while the receiver is ready; twelve items
//   can be in flight, one per cell. Each cell holds one round of combinational logic.
//   Reset (i_rst_n low, synchronous) empties all cells and drops the items in
//   flight; no result is offered afterwards until new items arrive.
//   Receiver stall: the last cell holds its result; cells behind it keep
//   moving into any empty slot, so input is taken until the chain is full.
// ----------------------------------------------------------------------------
module ascon_permutation
    import ascp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [WORD_W-1:0] i_word0,
    input  logic [WORD_W-1:0] i_word1,
    input  logic [WORD_W-1:0] i_word2,
    input  logic [WORD_W-1:0] i_word3,
    input  logic [WORD_W-1:0] i_word4,
    input  logic [OP_W-1:0]   i_op,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_out_word0,
    output logic [WORD_W-1:0] o_out_word1,
    output logic [WORD_W-1:0] o_out_word2,
    output logic [WORD_W-1:0] o_out_word3,
    output logic [WORD_W-1:0] o_out_word4
);

    // links between cells: index k feeds cell k
    logic  [N_ROUNDS:0] w_valid;
    logic  [N_ROUNDS:0] w_ready;
    t_item              w_item [N_ROUNDS+1];

    // input side
    assign w_valid[0] = i_valid;
    assign o_ready    = w_ready[0];
    assign w_item[0]  = {i_op, i_word4, i_word3, i_word2, i_word1, i_word0};

    // chain of round cells
    for (genvar k = 0; k < N_ROUNDS; k++) begin : g_cell
        ascp_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_item  (w_item[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_item  (w_item[k+1])
        );
    end

    // output side
    assign w_ready[N_ROUNDS] = i_ready;
    assign o_valid           = w_valid[N_ROUNDS];
    assign o_out_word0       = w_item[N_ROUNDS].state[0];
    assign o_out_word1       = w_item[N_ROUNDS].state[1];
    assign o_out_word2       = w_item[N_ROUNDS].state[2];
    assign o_out_word3       = w_item[N_ROUNDS].state[3];
    assign o_out_word4       = w_item[N_ROUNDS].state[4];

endmodule

/* sv/ascp_checker.sv */
// ----------------------------------------------------------------------------
// ascp_checker: port-level checks for ascon_permutation
// Tracks transfers in flight and checks output hold and occupancy rules.
// ----------------------------------------------------------------------------
module ascp_checker
    import ascp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [WORD_W-1:0] o_out_word0,
    input logic [WORD_W-1:0] o_out_word4
);

    localparam int unsigned CNT_W = $clog2(N_ROUNDS + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_in_xfer;
    logic             w_out_xfer;

    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_xfer = o_valid && i_ready;

    // items accepted but not yet delivered
    always_comb begin
        n_cnt = r_cnt;
        if (w_in_xfer && !w_out_xfer) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (w_out_xfer && !w_in_xfer) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_word0) && $stable(o_out_word4))
        else $error("stalled result changed or dropped");

    // no result without an item in flight
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != '0)
        else $error("result offered with nothing in flight");

    // never more items in flight than cells
    a_max_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(N_ROUNDS))
        else $error("more items in flight than cells");

    // an empty chain always takes input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> o_ready)
        else $error("empty chain refused input");

endmodule

bind ascon_permutation ascp_checker u_ascp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_word0 (o_out_word0),
    .o_out_word4 (o_out_word4)
);
